FILE: src/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } sha256_item_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int r);
    ror32 = (x >> r) | (x << (32 - r));
  endfunction

endpackage
`default_nettype wire

FILE: src/sha256_stream_hasher.sv
`default_nettype none
// SHA-256 over a byte stream. Each input transaction carries one message
// byte (tuser = 0) or a finish command (tuser = 1, data ignored). Bytes are
// queued in a two-entry queue and absorbed by the engine at one per cycle;
// every 64th byte triggers a compression (schedule load, 64 rounds at one
// round per cycle, chaining add), during which input transactions back up
// in the queue. A finish pads the message, runs one or two compressions,
// then presents the eight digest words in order, word 0 first, with tlast
// on word 7, and the hasher returns to its initial state for the next
// message. The round datapath sets the clock limit.
module sha256_stream_hasher (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // data_byte
  input  wire         s_tuser,   // op
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zeros
  output logic        m_tlast    // last_word
);
  sha256_pkg::sha256_item_t in_item, q_item;
  logic q_valid, q_ready;
  logic [31:0] word;
  logic [2:0]  index;

  assign in_item.op        = s_tuser;
  assign in_item.data_byte = s_tdata;

  sha256_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  sha256_engine u_engine (
    .clk(clk), .rst(rst),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_word(word), .out_index(index), .out_last(m_tlast)
  );

  assign m_tdata = {5'b0, index, word};
endmodule
`default_nettype wire

FILE: src/sha256_queue.sv
`default_nettype none
// Two-entry queue between the input side and the hashing engine.
module sha256_queue (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire sha256_pkg::sha256_item_t in_item,
  output logic                     out_valid,
  input  wire                      out_ready,
  output sha256_pkg::sha256_item_t out_item
);
  sha256_pkg::sha256_item_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: src/sha256_engine.sv
`default_nettype none
// Message words filled byte by byte, padding sequencer, one-round-per-cycle
// compression and digest output register. The sixteen schedule words hold
// the incoming block directly, most significant byte first.
module sha256_engine (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      item_valid,
  output logic                     item_ready,
  input  wire sha256_pkg::sha256_item_t item,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [31:0]              out_word,
  output logic [2:0]               out_index,
  output logic                     out_last
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]  state;
  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  pos;
  logic [63:0] bit_count;
  logic        finishing;
  logic        final_block;
  logic [5:0]  round;
  logic [2:0]  emit_idx;

  logic [7:0]  pad_byte;
  logic [31:0] wt, w15, w2, sm0, sm1, big0, big1, choose, major, t1, t2;

  assign item_ready = (state == ST_IDLE);
  assign out_word   = chain[emit_idx];
  assign out_index  = emit_idx;
  assign out_last   = (emit_idx == 3'd7);
  assign out_valid  = (state == ST_EMIT);

  // Padding byte at pos: zeros before the length field, then the count.
  always_comb begin
    if (final_block && pos >= 6'd56) begin
      pad_byte = bit_count[8 * (7 - int'(pos[2:0])) +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    w15 = w[1];
    w2  = w[14];
    sm0 = sha256_pkg::ror32(w15, 7) ^ sha256_pkg::ror32(w15, 18) ^ (w15 >> 3);
    sm1 = sha256_pkg::ror32(w2, 17) ^ sha256_pkg::ror32(w2, 19) ^ (w2 >> 10);
    wt  = (round < 6'd16) ? w[0] : (w[0] + sm0 + w[9] + sm1);
    big1 = sha256_pkg::ror32(v[4], 6) ^ sha256_pkg::ror32(v[4], 11)
         ^ sha256_pkg::ror32(v[4], 25);
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + big1 + choose + sha256_pkg::ROUND_K[round] + wt;
    big0 = sha256_pkg::ror32(v[0], 2) ^ sha256_pkg::ror32(v[0], 13)
         ^ sha256_pkg::ror32(v[0], 22);
    major = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = big0 + major;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      bit_count <= '0;
      finishing <= 1'b0;
      final_block <= 1'b0;
      round     <= '0;
      emit_idx  <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha256_pkg::INIT_H[i];
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.op == sha256_pkg::OP_ABSORB) begin
              w[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= item.data_byte;
              bit_count   <= bit_count + 64'd8;
              pos         <= pos + 6'd1;
              finishing   <= 1'b0;
              if (pos == 6'd63) begin
                state <= ST_LOAD;
              end
            end else begin
              w[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= sha256_pkg::PAD_MARK;
              pos         <= pos + 6'd1;
              finishing   <= 1'b1;
              final_block <= (pos < 6'd56);
              if (pos == 6'd63) begin
                state <= ST_LOAD;
              end else begin
                state <= ST_PAD;
              end
            end
          end
        end
        ST_PAD: begin
          // One padding byte per cycle up to the end of the block.
          w[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= pad_byte;
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          for (int j = 0; j < 8; j++) begin
            v[j] <= chain[j];
          end
          round <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          // Schedule window shifts so the current word is always w[0].
          for (int j = 0; j < 15; j++) begin
            w[j] <= w[j + 1];
          end
          w[15] <= wt;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int j = 0; j < 8; j++) begin
            chain[j] <= chain[j] + v[j];
          end
          if (!finishing) begin
            state <= ST_IDLE;
          end else if (final_block) begin
            emit_idx <= '0;
            state    <= ST_EMIT;
          end else begin
            final_block <= 1'b1;
            state       <= ST_PAD;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              state     <= ST_IDLE;
              pos       <= '0;
              bit_count <= '0;
              finishing <= 1'b0;
              final_block <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                chain[i] <= sha256_pkg::INIT_H[i];
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
